// ===== design/gwpmb_pkg.sv =====
package gwpmb_pkg;

    localparam int STORE_DEPTH_DEF  = 16;
    localparam int REGIONS_DEF      = 8;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int TARGET_BITS   = 3;
    localparam int PRIO_BITS     = 16;
    localparam int SURPRISE_BITS = 8;
    localparam int PAYLOAD_W     = 32;
    localparam int GAIN_BITS     = 10;

    // default width of one stored message: target, priority, surprise, payload
    localparam int ENTRY_BITS_DEF = 3 + PRIO_BITS + SURPRISE_BITS + PAYLOAD_BITS_DEF;

    localparam logic [GAIN_BITS-1:0]     GAIN_ONE     = 10'd256;
    localparam logic [GAIN_BITS-1:0]     GAIN_MAX     = 10'd768;
    localparam logic [GAIN_BITS-1:0]     GAIN_MIN     = 10'd26;
    localparam logic [SURPRISE_BITS-1:0] THRESH_RESET = 8'd77;
    localparam logic [PRIO_BITS-1:0]     PRIO_MAX     = 16'hFFFF;

    // floor(x / 5) = (x * RECIP_5) >> RECIP_SHIFT for x below 2**18
    localparam logic [16:0] RECIP_5     = 17'd52429;
    localparam int          RECIP_SHIFT = 18;

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_RECV  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_GAIN  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     cmd;
        logic [TARGET_BITS-1:0]   target;
        logic [PRIO_BITS-1:0]     priority_req;
        logic [SURPRISE_BITS-1:0] surprise;
        logic [PAYLOAD_W-1:0]     payload;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [PRIO_BITS-1:0]     out_priority;
        logic [SURPRISE_BITS-1:0] out_surprise;
        logic [PAYLOAD_W-1:0]     out_payload;
    } t_out_item;

    // gain table request: upd writes back the scaled gain, up selects the boost
    typedef struct packed {
        logic upd;
        logic up;
    } t_gain_op;

endpackage

// ===== design/gain_weighted_priority_message_bus_core.sv =====
// channel   direction  handshake                       contents
// command   in         start & !busy                   i_item (t_in_item)
// result    out        o_valid, one cycle, no stall    o_result (t_out_item)
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_data (surprise threshold)
//
// clear, send to a full store and receive with an empty store answer from idle;
// gain update passes through S_GAIN, send through S_SCALE and S_BOOST. receive
// scans the stored messages through the single read port of the message
// memory, then, unless the match is the last of them, closes the gap after it.
// the result strobe follows the last busy cycle; the next command may be
// taken in that same cycle. reset is synchronous and empties the store.
module gain_weighted_priority_message_bus_core import gwpmb_pkg::*; #(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int REGIONS      = REGIONS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_in_item                 i_item,
    output logic                     o_valid,
    output t_out_item                o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [SURPRISE_BITS-1:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int RW = $clog2(REGIONS);

    typedef struct packed {
        logic [RW-1:0]            tgt;
        logic [PRIO_BITS-1:0]     prio;
        logic [SURPRISE_BITS-1:0] sur;
        logic [PAYLOAD_BITS-1:0]  pay;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_BOOST,
        S_GAIN,
        S_SCAN,
        S_SHIFT
    } t_state;

    function automatic logic [RW-1:0] region_of(input logic [TARGET_BITS-1:0] t);
        logic [TARGET_BITS:0] v;
        v = {1'b0, t};
        for (int k = 0; k < 4; k++) begin
            if (int'(v) >= REGIONS) begin
                v = v - (TARGET_BITS + 1)'(REGIONS);
            end
        end
        return RW'(v);
    endfunction

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [RW-1:0]            r_tgt, n_tgt;
    logic [PRIO_BITS-1:0]     r_prio, n_prio;
    logic [SURPRISE_BITS-1:0] r_sur, n_sur;
    logic [PAYLOAD_BITS-1:0]  r_pay, n_pay;
    logic                     r_above, n_above;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_found, n_found;
    logic [AW-1:0]            r_best_idx, n_best_idx;
    t_entry                   r_best, n_best;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;
    logic [SURPRISE_BITS-1:0] r_thresh, n_thresh;

    logic [RW-1:0]            w_in_region;
    logic [RW-1:0]            w_gain_addr;
    t_gain_op                 w_gain_op;
    logic [GAIN_BITS-1:0]     w_gain;
    logic [AW-1:0]            w_rd_addr;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    t_entry                   w_wr_data;
    t_entry                   w_rd_entry;
    logic [EW-1:0]            w_rd_bits;
    logic [25:0]              w_scaled;
    logic [17:0]              w_boost;
    logic [PRIO_BITS-1:0]     w_send_prio;
    logic                     w_hit;

    assign w_in_region = region_of(i_item.target);
    assign w_rd_entry  = w_rd_bits;

    gwpmb_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (EW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_bits)
    );

    gwpmb_gain #(
        .REGIONS (REGIONS)
    ) u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_gain_addr),
        .i_op      (w_gain_op),
        .o_gain    (w_gain)
    );

    // priority * gain >> 8, then * 3 >> 1 when boosted, each saturating
    assign w_scaled = 26'(r_prio) * 26'(w_gain);
    assign w_boost  = 18'(r_prio) * 18'd3;

    always_comb begin
        if (r_above && w_boost[17]) begin
            w_send_prio = PRIO_MAX;
        end else if (r_above) begin
            w_send_prio = w_boost[16:1];
        end else begin
            w_send_prio = r_prio;
        end
    end

    assign w_hit = (w_rd_entry.tgt == r_tgt) && (!r_found || w_rd_entry.prio > r_best.prio);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_tgt       = r_tgt;
        n_prio      = r_prio;
        n_sur       = r_sur;
        n_pay       = r_pay;
        n_above     = r_above;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_thresh    = r_thresh;

        w_gain_addr = r_tgt;
        w_gain_op   = '{upd: 1'b0, up: r_above};
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = w_rd_entry;

        if (i_cfg_valid) begin
            n_thresh = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                w_gain_addr = w_in_region;
                if (start) begin
                    n_tgt   = w_in_region;
                    n_prio  = i_item.priority_req;
                    n_sur   = i_item.surprise;
                    n_pay   = i_item.payload[PAYLOAD_BITS-1:0];
                    n_above = i_item.surprise > r_thresh;
                    n_out   = '{status: ST_OK, default: '0};
                    unique case (i_item.cmd)
                        CMD_SEND: begin
                            if (r_count >= CW'(STORE_DEPTH)) begin
                                n_out.status = ST_FULL;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_state = S_SCALE;
                            end
                        end
                        CMD_RECV: begin
                            if (r_count == '0) begin
                                n_out.status = ST_NONE;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                        CMD_GAIN: begin
                            n_state = S_GAIN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCALE: begin
                n_prio  = (|w_scaled[25:24]) ? PRIO_MAX : w_scaled[23:8];
                n_state = S_BOOST;
            end
            S_BOOST: begin
                w_wr_en     = 1'b1;
                w_wr_addr   = r_count[AW-1:0];
                w_wr_data   = '{tgt: r_tgt, prio: w_send_prio, sur: r_sur, pay: r_pay};
                n_count     = r_count + CW'(1);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_GAIN: begin
                w_gain_op.upd = 1'b1;
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                // read data holds entry r_idx; next address goes out now
                w_rd_addr = r_idx + AW'(1);
                n_idx     = r_idx + AW'(1);
                if (w_hit) begin
                    n_found    = 1'b1;
                    n_best_idx = r_idx;
                    n_best     = w_rd_entry;
                end
                if (CW'(r_idx) + CW'(1) == r_count) begin
                    if (!n_found) begin
                        n_out.status = ST_NONE;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end else if (CW'(n_best_idx) + CW'(1) == r_count) begin
                        n_out        = '{status: ST_OK,
                                         out_priority: n_best.prio,
                                         out_surprise: n_best.sur,
                                         out_payload: PAYLOAD_W'(n_best.pay)};
                        n_out_valid  = 1'b1;
                        n_count      = r_count - CW'(1);
                        n_state      = S_IDLE;
                    end else begin
                        // close the gap from the match onward
                        w_rd_addr = n_best_idx + AW'(1);
                        n_idx     = n_best_idx;
                        n_state   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // read data holds entry r_idx + 1, moved down to r_idx
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = w_rd_entry;
                w_rd_addr = r_idx + AW'(2);
                n_idx     = r_idx + AW'(1);
                if (CW'(r_idx) + CW'(2) == r_count) begin
                    n_out       = '{status: ST_OK,
                                    out_priority: r_best.prio,
                                    out_surprise: r_best.sur,
                                    out_payload: PAYLOAD_W'(r_best.pay)};
                    n_out_valid = 1'b1;
                    n_count     = r_count - CW'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_thresh    <= n_thresh;
            r_found     <= n_found;
            r_tgt       <= n_tgt;
            r_prio      <= n_prio;
            r_sur       <= n_sur;
            r_pay       <= n_pay;
            r_above     <= n_above;
            r_idx       <= n_idx;
            r_best_idx  <= n_best_idx;
            r_best      <= n_best;
            r_out       <= n_out;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== design/gwpmb_store.sv =====
module gwpmb_store import gwpmb_pkg::*; #(
    parameter int DEPTH = STORE_DEPTH_DEF,
    parameter int WIDTH = ENTRY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/gwpmb_gain.sv =====
module gwpmb_gain import gwpmb_pkg::*; #(
    parameter int REGIONS = REGIONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [$clog2(REGIONS)-1:0] i_rd_addr,
    input  t_gain_op                   i_op,
    output logic [GAIN_BITS-1:0]       o_gain
);

    localparam int RW = $clog2(REGIONS);

    logic [GAIN_BITS-1:0] r_mem [REGIONS];
    logic [REGIONS-1:0]   r_valid;
    logic [GAIN_BITS-1:0] r_rdata;
    logic                 r_rvalid;
    logic [RW-1:0]        r_addr;

    logic [GAIN_BITS-1:0] w_gain;
    logic [14:0]          w_g19;
    logic [12:0]          w_dividend;
    logic [29:0]          w_prod;
    logic [11:0]          w_quot;
    logic [GAIN_BITS-1:0] w_new;

    // a region never written still holds its reset gain of 1.0
    assign w_gain = r_rvalid ? r_rdata : GAIN_ONE;

    // gain * 6 / 5 going up, gain * 19 / 20 = (gain * 19 / 4) / 5 going down
    assign w_g19      = {w_gain, 4'b0} + {4'b0, w_gain, 1'b0} + {5'b0, w_gain};
    assign w_dividend = i_op.up ? ({1'b0, w_gain, 2'b0} + {2'b0, w_gain, 1'b0})
                                : w_g19[14:2];
    assign w_prod     = 30'(w_dividend) * 30'(RECIP_5);
    assign w_quot     = w_prod[29:RECIP_SHIFT];

    always_comb begin
        if (i_op.up) begin
            w_new = (w_quot > 12'(GAIN_MAX)) ? GAIN_MAX : w_quot[GAIN_BITS-1:0];
        end else begin
            w_new = (w_quot < 12'(GAIN_MIN)) ? GAIN_MIN : w_quot[GAIN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.upd) begin
            r_mem[r_addr] <= w_new;
        end
        r_rdata <= r_mem[i_rd_addr];
        r_addr  <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_op.upd) begin
                r_valid[r_addr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_rd_addr];
        end
    end

    assign o_gain = w_gain;

endmodule

// ===== tb/gain_weighted_priority_message_bus_core_test.sv =====
module gain_weighted_priority_message_bus_core_test;
    import gwpmb_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 2 * STORE_DEPTH_DEF + 8;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 255;
    localparam int NUM_DIR       = 22;

    typedef struct packed {
        logic [TARGET_BITS-1:0]   target;
        logic [PRIO_BITS-1:0]     prio;
        logic [SURPRISE_BITS-1:0] sur;
        logic [PAYLOAD_W-1:0]     pay;
    } t_msg;

    typedef struct packed {
        t_in_item  item;
        logic      pinned;
        t_out_item result;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_in_item                 i_item;
    logic                     o_valid;
    t_out_item                o_result;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [SURPRISE_BITS-1:0] i_cfg_data;

    // typed-in expectation travels with the command
    logic      pin_en;
    t_out_item pin_res;

    // bus state as the testbench sees it
    t_msg                     msg_store [STORE_DEPTH_DEF];
    int                       msg_count = 0;
    logic [GAIN_BITS-1:0]     gain_tab [REGIONS_DEF] = '{default: GAIN_ONE};
    logic [SURPRISE_BITS-1:0] thresh = THRESH_RESET;
    t_out_item                pending_results [$];

    int errors = 0;
    int idle_cycles = 0;
    int n_items = 0, n_send = 0, n_full = 0, n_recv = 0, n_empty = 0;
    int n_clear = 0, n_gain = 0, n_gain_hi = 0, n_gain_lo = 0, n_cfg = 0;
    int cur_thr = THRESH_RESET;

    // random phases: threshold (-1 random), command mix in percent, target mask, gaps
    int ph_thr   [NUM_PHASES] = '{0, 255, -1, 0, -1, 128};
    int ph_send  [NUM_PHASES] = '{45, 30, 75, 30, 40, 75};
    int ph_recv  [NUM_PHASES] = '{35, 25, 20, 25, 40, 20};
    int ph_clear [NUM_PHASES] = '{3, 2, 1, 2, 5, 1};
    int ph_tmask [NUM_PHASES] = '{7, 1, 7, 1, 7, 3};
    bit ph_gaps  [NUM_PHASES] = '{1, 1, 0, 1, 1, 1};

    t_dir_row dir_rows [NUM_DIR] = '{
        '{'{CMD_RECV, 3'd0, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_NONE, 16'h0, 8'h0, 32'h0}},
        '{'{CMD_SEND, 3'd0, 16'hFFFF, 8'd0, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 16'h0, 8'h0, 32'h0}},
        '{'{CMD_SEND, 3'd0, 16'h0000, 8'd255, 32'h0}, 1'b1, '{ST_OK, 16'h0, 8'h0, 32'h0}},
        '{'{CMD_SEND, 3'd7, 16'h0100, 8'd78, 32'hA5A5_A5A5}, 1'b0, '0},
        '{'{CMD_SEND, 3'd7, 16'h0100, 8'd77, 32'h5A5A_5A5A}, 1'b0, '0},
        '{'{CMD_RECV, 3'd0, 16'h0000, 8'd0, 32'h0},
          1'b1, '{ST_OK, 16'hFFFF, 8'h00, 32'hFFFF_FFFF}},
        // zero priority is still found
        '{'{CMD_RECV, 3'd0, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_OK, 16'h0, 8'hFF, 32'h0}},
        '{'{CMD_RECV, 3'd0, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_NONE, 16'h0, 8'h0, 32'h0}},
        '{'{CMD_RECV, 3'd7, 16'h0000, 8'd0, 32'h0},
          1'b1, '{ST_OK, 16'h0180, 8'd78, 32'hA5A5_A5A5}},
        '{'{CMD_GAIN, 3'd3, 16'h0000, 8'd255, 32'h0}, 1'b1, '{ST_OK, 16'h0, 8'h0, 32'h0}},
        '{'{CMD_GAIN, 3'd3, 16'h0000, 8'd0, 32'h0}, 1'b0, '0},
        // gain and boost both saturate
        '{'{CMD_SEND, 3'd3, 16'hFFFF, 8'd255, 32'h1234_5678}, 1'b0, '0},
        '{'{CMD_RECV, 3'd3, 16'h0000, 8'd0, 32'h0}, 1'b0, '0},
        '{'{CMD_CLEAR, 3'd0, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_OK, 16'h0, 8'h0, 32'h0}},
        '{'{CMD_RECV, 3'd7, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_NONE, 16'h0, 8'h0, 32'h0}},
        // equal priorities go out oldest first
        '{'{CMD_SEND, 3'd2, 16'h1234, 8'd0, 32'h1}, 1'b0, '0},
        '{'{CMD_SEND, 3'd2, 16'h1234, 8'd0, 32'h2}, 1'b0, '0},
        '{'{CMD_SEND, 3'd5, 16'h2000, 8'd200, 32'h3}, 1'b0, '0},
        '{'{CMD_RECV, 3'd2, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_OK, 16'h1234, 8'h0, 32'h1}},
        '{'{CMD_RECV, 3'd2, 16'h0000, 8'd0, 32'h0}, 1'b1, '{ST_OK, 16'h1234, 8'h0, 32'h2}},
        '{'{CMD_RECV, 3'd5, 16'h0000, 8'd0, 32'h0}, 1'b0, '0},
        '{'{CMD_GAIN, 3'd0, 16'h0000, 8'd77, 32'h0}, 1'b0, '0}
    };

    gain_weighted_priority_message_bus_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_bus_result(t_in_item it);
        t_out_item   res;
        int unsigned tg;
        int unsigned p;
        int unsigned g;
        bit          above;
        bit          found;
        int          best;
        res = '0;
        res.status = ST_OK;
        tg = it.target % REGIONS_DEF;
        above = it.surprise > thresh;
        found = 1'b0;
        best = 0;
        case (it.cmd)
            CMD_SEND: begin
                n_send++;
                if (msg_count >= STORE_DEPTH_DEF) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    p = (32'(it.priority_req) * 32'(gain_tab[tg])) >> 8;
                    if (p > PRIO_MAX) p = PRIO_MAX;
                    if (above) begin
                        p = (p * 3) >> 1;
                        if (p > PRIO_MAX) p = PRIO_MAX;
                    end
                    msg_store[msg_count].target = TARGET_BITS'(tg);
                    msg_store[msg_count].prio   = PRIO_BITS'(p);
                    msg_store[msg_count].sur    = it.surprise;
                    msg_store[msg_count].pay    = it.payload;
                    msg_count++;
                end
            end
            CMD_RECV: begin
                n_recv++;
                for (int i = 0; i < msg_count; i++) begin
                    if (msg_store[i].target == tg &&
                        (!found || msg_store[i].prio > msg_store[best].prio)) begin
                        found = 1'b1;
                        best = i;
                    end
                end
                if (!found) begin
                    res.status = ST_NONE;
                    n_empty++;
                end else begin
                    res.out_priority = msg_store[best].prio;
                    res.out_surprise = msg_store[best].sur;
                    res.out_payload  = msg_store[best].pay;
                    // close the gap, keeping the order of the rest
                    for (int i = best; i < msg_count - 1; i++)
                        msg_store[i] = msg_store[i + 1];
                    msg_count--;
                end
            end
            CMD_CLEAR: begin
                n_clear++;
                msg_count = 0;
            end
            default: begin
                n_gain++;
                g = gain_tab[tg];
                if (above) begin
                    g = (g * 6) / 5;
                    if (g >= GAIN_MAX) begin
                        g = GAIN_MAX;
                        n_gain_hi++;
                    end
                end else begin
                    g = (g * 19) / 20;
                    if (g <= GAIN_MIN) begin
                        g = GAIN_MIN;
                        n_gain_lo++;
                    end
                end
                gain_tab[tg] = GAIN_BITS'(g);
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, name, exp_v, got_v);
        end
    endtask

    task automatic compare_result(t_out_item exp_r, t_out_item got);
        check_field("status", exp_r.status, got.status);
        check_field("out_priority", exp_r.out_priority, got.out_priority);
        check_field("out_surprise", exp_r.out_surprise, got.out_surprise);
        check_field("out_payload", exp_r.out_payload, got.out_payload);
    endtask

    always @(posedge i_clk) begin : bus_monitor
        bit        moved;
        t_out_item predicted;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: expected none, got %h",
                             $time, o_result);
                end else begin
                    compare_result(pending_results.pop_front(), o_result);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                thresh = i_cfg_data;
                n_cfg++;
            end
            if (start && !busy) begin
                moved = 1'b1;
                n_items++;
                predicted = predict_bus_result(i_item);
                pending_results.push_back(pin_en ? pin_res : predicted);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL gain_weighted_priority_message_bus_core");
        $finish;
    end

    // returns at the edge where the command transaction is taken
    task automatic issue(t_in_item it, logic pin, t_out_item pres, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_item  <= it;
        pin_en  <= pin;
        pin_res <= pres;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_threshold(int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= SURPRISE_BITS'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_thr = value;
    endtask

    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item random_command(int ph);
        t_in_item it;
        int       roll;
        int       s;
        roll = $urandom_range(99);
        if (roll < ph_send[ph])
            it.cmd = CMD_SEND;
        else if (roll < ph_send[ph] + ph_recv[ph])
            it.cmd = CMD_RECV;
        else if (roll < ph_send[ph] + ph_recv[ph] + ph_clear[ph])
            it.cmd = CMD_CLEAR;
        else
            it.cmd = CMD_GAIN;
        it.target = TARGET_BITS'($urandom & ph_tmask[ph]);
        roll = $urandom_range(9);
        if (roll == 0)
            it.priority_req = '0;
        else if (roll == 1)
            it.priority_req = '1;
        else
            it.priority_req = PRIO_BITS'($urandom);
        // surprise right around the threshold now and then
        if ($urandom_range(5) == 0) begin
            s = cur_thr + $urandom_range(2) - 1;
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            it.surprise = SURPRISE_BITS'(s);
        end else begin
            it.surprise = SURPRISE_BITS'($urandom);
        end
        it.payload = $urandom;
        return it;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        pin_en      = 1'b0;
        pin_res     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].result,
                  (i % 4 == 3) ? 2 : 0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_threshold(ph_thr[ph] < 0 ? $urandom_range(1, 254) : ph_thr[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(199) == 0) drain_results();
                issue(random_command(ph), 1'b0, '0, ph_gaps[ph] ? gap_cycles() : 0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d commands, %0d threshold writes, %0d sends (%0d on a full store)",
                 n_items, n_cfg, n_send, n_full);
        $display("  %0d receives (%0d found nothing), %0d clears, %0d gain updates (%0d/%0d clamped)",
                 n_recv, n_empty, n_clear, n_gain, n_gain_hi, n_gain_lo);
        if (errors == 0)
            $display("PASS gain_weighted_priority_message_bus_core");
        else
            $display("FAIL gain_weighted_priority_message_bus_core");
        $finish;
    end

endmodule

// ===== gain_weighted_priority_message_bus_core.f =====
design/gwpmb_pkg.sv
design/gwpmb_store.sv
design/gwpmb_gain.sv
design/gain_weighted_priority_message_bus_core.sv
tb/gain_weighted_priority_message_bus_core_test.sv
